// ----- rtl/vslo_pkg.sv -----
// ----------------------------------------------------------------------------
// vslo_pkg
// Shared types and constants for the voxel store with layer occupancy.
// ----------------------------------------------------------------------------
package vslo_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int KIND_W     = 1;
    localparam int POS_XZ_W   = 6;
    localparam int POS_Y_W    = 10;
    localparam int NEW_ID_W   = 16;
    localparam int READ_ID_W  = 16;
    localparam int TOP_W      = 8;
    localparam int COUNT_W    = 9;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_READ  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN
    } state_t;

endpackage

// ----- rtl/voxel_store_layer_occupancy.sv -----
// ----------------------------------------------------------------------------
// voxel_store_layer_occupancy
// Voxel id store with a per-layer occupancy count and a top layer tracker.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one transaction per cell
// access: kind selects read or write, pos_x/pos_y/pos_z address the cell
// and new_id is the id to store. The output channel (out_valid/out_ready)
// returns exactly one transaction per input with the read id, the top layer
// and the occupancy count of the addressed layer.
// On accept the block reads the cell memory and the layer count memory;
// in the modify step it writes both back for a write and loads the output
// register. When a write empties the current top layer, the load waits for
// a downward scan of the layer count memory that visits at most as many
// layers as the top layer's index. The single read port of the count memory
// sets the scan pace. One item is in flight at a time.
// After reset the block clears both memories, one cell address per cycle,
// over all WIDTH*HEIGHT*DEPTH cell addresses (65536 at default sizes);
// in_ready stays low meanwhile. A stalled receiver holds the result in the
// output register; a following item may be accepted and is held at
// write-back until the output register frees up.
// ----------------------------------------------------------------------------
module voxel_store_layer_occupancy #(
    parameter int WIDTH   = 16,
    parameter int HEIGHT  = 256,
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [vslo_pkg::KIND_W-1:0]          kind,
    input  logic [vslo_pkg::POS_XZ_W-1:0]        pos_x,
    input  logic [vslo_pkg::POS_Y_W-1:0]         pos_y,
    input  logic [vslo_pkg::POS_XZ_W-1:0]        pos_z,
    input  logic [vslo_pkg::NEW_ID_W-1:0]        new_id,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [vslo_pkg::READ_ID_W-1:0]       read_id,
    output logic [vslo_pkg::TOP_W-1:0]           top_layer,
    output logic [vslo_pkg::COUNT_W-1:0]         layer_count
);

    localparam int CELLS      = WIDTH * HEIGHT * DEPTH;
    localparam int ADDR_BITS  = $clog2(CELLS);
    localparam int LY_BITS    = $clog2(HEIGHT);
    localparam int LAYER_AREA = WIDTH * DEPTH;
    localparam int CNT_BITS   = $clog2(LAYER_AREA + 1);

    // Memories.
    logic [ID_BITS-1:0]  cell_mem [CELLS];
    logic [CNT_BITS-1:0] cnt_mem  [HEIGHT];

    // Memory ports.
    logic                 cell_re;
    logic                 cell_we;
    logic [ADDR_BITS-1:0] cell_waddr;
    logic [ID_BITS-1:0]   cell_wdata;
    logic [ID_BITS-1:0]   cell_rd_q;
    logic                 cnt_re;
    logic [LY_BITS-1:0]   cnt_raddr;
    logic                 cnt_we;
    logic [LY_BITS-1:0]   cnt_waddr;
    logic [CNT_BITS-1:0]  cnt_wdata;
    logic [CNT_BITS-1:0]  cnt_rd_q;

    // Sequencer and item registers.
    vslo_pkg::state_t     state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [LY_BITS-1:0]   top_reg, top_next;
    logic [LY_BITS-1:0]   scan_reg, scan_next;
    logic                 wr_reg;
    logic                 inside_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [LY_BITS-1:0]   ly_reg;
    logic [ID_BITS-1:0]   id_reg;

    // Output register.
    logic                              out_valid_reg, out_valid_next;
    logic [vslo_pkg::READ_ID_W-1:0]    read_id_reg;
    logic [vslo_pkg::TOP_W-1:0]        top_out_reg;
    logic [vslo_pkg::COUNT_W-1:0]      count_out_reg;

    // Decoded input address.
    logic                 in_inside;
    logic [ADDR_BITS-1:0] in_addr;
    logic [LY_BITS-1:0]   in_layer;

    // Modify-stage terms.
    logic                 accept;
    logic                 out_free;
    logic                 clr_last;
    logic                 do_write;
    logic                 id_nz;
    logic                 prev_nz;
    logic [CNT_BITS-1:0]  cnt_new;
    logic [LY_BITS-1:0]   top_mod;
    logic                 need_scan;
    logic                 scan_hit;
    logic                 scan_fin;
    logic                 out_load;
    logic [vslo_pkg::READ_ID_W-1:0] read_id_d;
    logic [vslo_pkg::TOP_W-1:0]     top_d;
    logic [vslo_pkg::COUNT_W-1:0]   count_d;

    vslo_addr #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .DEPTH  (DEPTH)
    ) u_addr (
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .in_grid   (in_inside),
        .cell_addr (in_addr),
        .layer     (in_layer)
    );

    assign in_ready  = (state_reg == vslo_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign clr_last  = (clr_reg == ADDR_BITS'(CELLS - 1));
    assign do_write  = wr_reg && inside_reg;

    // Count update and top layer tracking for a write.
    assign id_nz     = (id_reg != '0);
    assign prev_nz   = (cell_rd_q != '0);
    always_comb
    begin
        if (id_nz && !prev_nz)
        begin
            cnt_new = cnt_rd_q + CNT_BITS'(1);
        end
        else if (!id_nz && prev_nz && (cnt_rd_q != '0))
        begin
            cnt_new = cnt_rd_q - CNT_BITS'(1);
        end
        else
        begin
            cnt_new = cnt_rd_q;
        end
    end
    assign top_mod   = (id_nz && (ly_reg > top_reg)) ? ly_reg : top_reg;
    assign need_scan = do_write && (cnt_new == '0) && (top_mod == ly_reg)
                    && (ly_reg != '0);
    assign scan_hit  = (cnt_rd_q != '0);
    assign scan_fin  = scan_hit || (scan_reg == '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vslo_pkg::S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = vslo_pkg::S_IDLE;
                end
            end
            vslo_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = vslo_pkg::S_MOD;
                end
            end
            vslo_pkg::S_MOD:
            begin
                if (need_scan)
                begin
                    state_next = vslo_pkg::S_SCAN;
                end
                else if (out_free)
                begin
                    state_next = vslo_pkg::S_IDLE;
                end
            end
            vslo_pkg::S_SCAN:
            begin
                if (scan_fin && out_free)
                begin
                    state_next = vslo_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vslo_pkg::S_CLEAR;
            end
        endcase
    end

    // Memory controls, register updates and result values.
    always_comb
    begin
        cell_re    = 1'b0;
        cell_we    = 1'b0;
        cell_waddr = addr_reg;
        cell_wdata = id_reg;
        cnt_re     = 1'b0;
        cnt_raddr  = in_layer;
        cnt_we     = 1'b0;
        cnt_waddr  = ly_reg;
        cnt_wdata  = cnt_new;
        clr_next   = clr_reg;
        top_next   = top_reg;
        scan_next  = scan_reg;
        out_load   = 1'b0;
        read_id_d  = '0;
        top_d      = vslo_pkg::TOP_W'(top_reg);
        count_d    = '0;
        unique case (state_reg)
            vslo_pkg::S_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_reg;
                cell_wdata = '0;
                cnt_we     = (32'(clr_reg) < 32'(HEIGHT));
                cnt_waddr  = clr_reg[LY_BITS-1:0];
                cnt_wdata  = '0;
                clr_next   = clr_reg + ADDR_BITS'(1);
            end
            vslo_pkg::S_IDLE:
            begin
                cell_re = accept;
                cnt_re  = accept;
            end
            vslo_pkg::S_MOD:
            begin
                if (need_scan || out_free)
                begin
                    cell_we  = do_write;
                    cnt_we   = do_write;
                    if (do_write)
                    begin
                        top_next = top_mod;
                    end
                end
                if (need_scan)
                begin
                    // Layer ly is now empty; start looking one layer below.
                    cnt_re    = 1'b1;
                    cnt_raddr = ly_reg - LY_BITS'(1);
                    scan_next = ly_reg - LY_BITS'(1);
                end
                else
                begin
                    out_load = out_free;
                    if (inside_reg)
                    begin
                        if (!wr_reg)
                        begin
                            read_id_d = vslo_pkg::READ_ID_W'(cell_rd_q);
                            count_d   = vslo_pkg::COUNT_W'(cnt_rd_q);
                        end
                        else
                        begin
                            count_d = vslo_pkg::COUNT_W'(cnt_new);
                        end
                    end
                    top_d = vslo_pkg::TOP_W'(do_write ? top_mod : top_reg);
                end
            end
            vslo_pkg::S_SCAN:
            begin
                if (scan_fin)
                begin
                    // A scan that finds nothing leaves the top layer as it was.
                    out_load = out_free;
                    if (out_free && scan_hit)
                    begin
                        top_next = scan_reg;
                    end
                    top_d = vslo_pkg::TOP_W'(scan_hit ? scan_reg : top_reg);
                end
                else
                begin
                    cnt_re    = 1'b1;
                    cnt_raddr = scan_reg - LY_BITS'(1);
                    scan_next = scan_reg - LY_BITS'(1);
                end
            end
            default:
            begin
                cell_re = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Cell memory.
    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        if (cell_re)
        begin
            cell_rd_q <= cell_mem[in_addr];
        end
    end

    // Layer count memory.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_q <= cnt_mem[cnt_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vslo_pkg::S_CLEAR;
            clr_reg       <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (accept)
        begin
            wr_reg     <= (kind == vslo_pkg::KIND_WRITE);
            inside_reg <= in_inside;
            addr_reg   <= in_addr;
            ly_reg     <= in_layer;
            id_reg     <= ID_BITS'(32'(new_id));
        end
        if (out_load)
        begin
            read_id_reg   <= read_id_d;
            top_out_reg   <= top_d;
            count_out_reg <= count_d;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_id     = read_id_reg;
    assign top_layer   = top_out_reg;
    assign layer_count = count_out_reg;

`ifndef SYNTHESIS
    // An accepted transaction always moves on to the modify step.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == vslo_pkg::S_MOD))
        else $error("accepted transaction did not reach the modify step");

    // The top layer only moves while a write is being finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vslo_pkg::S_IDLE) |=> $stable(top_reg))
        else $error("top layer changed while idle");

    // A layer count never exceeds the cells in one layer.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> (32'(cnt_wdata) <= 32'(LAYER_AREA)))
        else $error("layer count written beyond layer size");

    // A scan starts only after the addressed layer went empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == vslo_pkg::S_MOD) && (state_next == vslo_pkg::S_SCAN))
            |-> (cnt_we && (cnt_wdata == '0)))
        else $error("top layer scan started on an occupied layer");
`endif

endmodule

// ----- rtl/vslo_addr.sv -----
// ----------------------------------------------------------------------------
// vslo_addr
// Bounds check and linear cell address for one coordinate triple.
// ----------------------------------------------------------------------------
module vslo_addr #(
    parameter int WIDTH  = 16,
    parameter int HEIGHT = 256,
    parameter int DEPTH  = 16
) (
    input  logic [vslo_pkg::POS_XZ_W-1:0]        pos_x,
    input  logic [vslo_pkg::POS_Y_W-1:0]         pos_y,
    input  logic [vslo_pkg::POS_XZ_W-1:0]        pos_z,
    output logic                                 in_grid,
    output logic [$clog2(WIDTH*HEIGHT*DEPTH)-1:0] cell_addr,
    output logic [$clog2(HEIGHT)-1:0]            layer
);

    localparam int CELLS       = WIDTH * HEIGHT * DEPTH;
    localparam int ADDR_BITS   = $clog2(CELLS);
    localparam int LY_BITS     = $clog2(HEIGHT);
    localparam int LAYER_CELLS = HEIGHT * DEPTH;

    logic [31:0] x_val;
    logic [31:0] y_val;
    logic [31:0] z_val;

    // Negative coordinates have the sign bit set; the rest compare as unsigned.
    assign x_val = 32'(pos_x[vslo_pkg::POS_XZ_W-2:0]);
    assign y_val = 32'(pos_y[vslo_pkg::POS_Y_W-2:0]);
    assign z_val = 32'(pos_z[vslo_pkg::POS_XZ_W-2:0]);

    assign in_grid = !pos_x[vslo_pkg::POS_XZ_W-1] && (x_val < 32'(WIDTH))
                  && !pos_y[vslo_pkg::POS_Y_W-1]  && (y_val < 32'(HEIGHT))
                  && !pos_z[vslo_pkg::POS_XZ_W-1] && (z_val < 32'(DEPTH));

    // x-major layout: x, then layer, then z.
    assign cell_addr = ADDR_BITS'(x_val * 32'(LAYER_CELLS) + y_val * 32'(DEPTH) + z_val);
    assign layer     = LY_BITS'(y_val);

endmodule
